>>> rtl/drsc_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic resolution scale controller - shared definitions
// Field widths, register indexes, reset values and the types passed between
// the configuration block, the scaling core and the top level.
// ----------------------------------------------------------------------------
package drsc_pkg;

	// Field widths
	localparam int TIME_W  = 18;
	localparam int ACC_W   = 22;
	localparam int SCALE_W = 9;
	localparam int COUNT_W = 4;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 18;

	// Fixed limits of the scale and target
	localparam logic [TIME_W-1:0]  MIN_TARGET = 18'd256;
	localparam logic [SCALE_W-1:0] SCALE_LOW  = 9'd64;
	localparam logic [SCALE_W-1:0] SCALE_ONE  = 9'd256;
	localparam logic [SCALE_W-1:0] SCALE_STEP = 9'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;

	// Register values after reset
	localparam logic [TIME_W-1:0]  TARGET_RESET    = 18'd4267;
	localparam logic [SCALE_W-1:0] MIN_SCALE_RESET = 9'd172;
	localparam logic [SCALE_W-1:0] MAX_SCALE_RESET = 9'd256;
	localparam logic [COUNT_W-1:0] OVER_RESET      = 4'd3;
	localparam logic [COUNT_W-1:0] UNDER_RESET     = 4'd8;

	// Division by five as a multiplication by the rounded-up reciprocal.
	// Exact for dividends below 2**26.
	localparam int          DIV5_SHIFT = 27;
	localparam int          SUM_W      = 25;
	localparam int          PROD_W     = 50;
	localparam logic [SUM_W-1:0] DIV5_MUL = 25'd26843546;

	// Threshold factors: acc*25 > target*416 and acc*50 < target*656
	localparam int CMP_W = 28;
	localparam logic [CMP_W-1:0] OVER_ACC_MUL   = 28'd25;
	localparam logic [CMP_W-1:0] OVER_TGT_MUL   = 28'd416;
	localparam logic [CMP_W-1:0] UNDER_ACC_MUL  = 28'd50;
	localparam logic [CMP_W-1:0] UNDER_TGT_MUL  = 28'd656;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_TARGET_TIME = 3'd0,
		CFG_MIN_SCALE   = 3'd1,
		CFG_MAX_SCALE   = 3'd2,
		CFG_OVER_NEED   = 3'd3,
		CFG_UNDER_NEED  = 3'd4
	} cfg_idx_t;

	// Item kinds
	typedef enum logic {
		KIND_RESTART = 1'b0,
		KIND_SAMPLE  = 1'b1
	} kind_t;

	// Effective (clamped) configuration
	typedef struct packed {
		logic [TIME_W-1:0]  target;
		logic [SCALE_W-1:0] scale_min;
		logic [SCALE_W-1:0] scale_max;
		logic [COUNT_W-1:0] over_need;
		logic [COUNT_W-1:0] under_need;
	} cfg_eff_t;

	// One result
	typedef struct packed {
		logic [SCALE_W-1:0] scale_level;
		logic               scale_changed;
		logic [TIME_W-1:0]  smoothed_time;
	} result_t;

endpackage

>>> rtl/drsc_in_if.sv
// ----------------------------------------------------------------------------
// Frame item channel
// Valid/ready channel carrying one restart or frame time item.
// ----------------------------------------------------------------------------
interface drsc_in_if import drsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [TIME_W-1:0] sample_time;

	modport source (output valid, kind, sample_time, input ready);
	modport sink   (input valid, kind, sample_time, output ready);
endinterface

>>> rtl/drsc_out_if.sv
// ----------------------------------------------------------------------------
// Scale result channel
// Valid/ready channel carrying the render scale after each item.
// ----------------------------------------------------------------------------
interface drsc_out_if import drsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCALE_W-1:0] scale_level;
	logic               scale_changed;
	logic [TIME_W-1:0]  smoothed_time;

	modport source (output valid, scale_level, scale_changed, smoothed_time, input ready);
	modport sink   (input valid, scale_level, scale_changed, smoothed_time, output ready);
endinterface

>>> rtl/drsc_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the five writable registers and presents them with the target and the scale limits clamped.
// ----------------------------------------------------------------------------
module drsc_cfg import drsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	output cfg_eff_t          cfg
);

	logic [TIME_W-1:0]  target_q;
	logic [SCALE_W-1:0] min_scale_q;
	logic [SCALE_W-1:0] max_scale_q;
	logic [COUNT_W-1:0] over_need_q;
	logic [COUNT_W-1:0] under_need_q;
	logic [SCALE_W-1:0] lo;
	logic [SCALE_W-1:0] hi;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= TARGET_RESET;
			min_scale_q  <= MIN_SCALE_RESET;
			max_scale_q  <= MAX_SCALE_RESET;
			over_need_q  <= OVER_RESET;
			under_need_q <= UNDER_RESET;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_TARGET_TIME: target_q     <= wr_data;
				CFG_MIN_SCALE:   min_scale_q  <= wr_data[SCALE_W-1:0];
				CFG_MAX_SCALE:   max_scale_q  <= wr_data[SCALE_W-1:0];
				CFG_OVER_NEED:   over_need_q  <= wr_data[COUNT_W-1:0];
				CFG_UNDER_NEED:  under_need_q <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the scale limits: the ceiling never sits below the floor.
	always_comb begin
		lo = min_scale_q;
		if (lo < SCALE_LOW) lo = SCALE_LOW;
		if (lo > SCALE_ONE) lo = SCALE_ONE;
		hi = max_scale_q;
		if (hi < lo) hi = lo;
		if (hi > SCALE_ONE) hi = SCALE_ONE;
	end

	assign cfg.target     = (target_q < MIN_TARGET) ? MIN_TARGET : target_q;
	assign cfg.scale_min  = lo;
	assign cfg.scale_max  = hi;
	assign cfg.over_need  = over_need_q;
	assign cfg.under_need = under_need_q;

endmodule

>>> rtl/drsc_core.sv
// ----------------------------------------------------------------------------
// Scaling core
// Holds the smoothed frame time, the render scale and the band counters,
// and works out the next state and the result for one item.
// ----------------------------------------------------------------------------
module drsc_core import drsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_eff_t          cfg,
	input  logic              upd_en,
	input  logic              kind,
	input  logic [TIME_W-1:0] sample_time,
	output result_t           res
);

	logic [ACC_W-1:0]   acc_q;
	logic [SCALE_W-1:0] scale_q;
	logic [COUNT_W-1:0] over_q;
	logic [COUNT_W-1:0] under_q;

	logic [ACC_W-1:0]   acc_d;
	logic [SCALE_W-1:0] scale_d;
	logic [COUNT_W-1:0] over_d;
	logic [COUNT_W-1:0] under_d;

	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	logic [ACC_W-1:0]   acc_avg;
	logic [CMP_W-1:0]   over_lhs;
	logic [CMP_W-1:0]   over_rhs;
	logic [CMP_W-1:0]   under_lhs;
	logic [CMP_W-1:0]   under_rhs;
	logic               is_over;
	logic               is_under;
	logic [COUNT_W-1:0] over_inc;
	logic [COUNT_W-1:0] under_inc;
	logic [SCALE_W-1:0] scale_dn;
	logic [SCALE_W:0]   scale_up;

	// Exponential average: floor((4*acc + sample*16) / 5)
	assign sum     = {1'b0, acc_q, 2'b00} + {3'b000, sample_time, 4'b0000};
	assign prod    = PROD_W'(sum) * PROD_W'(DIV5_MUL);
	assign acc_avg = prod[DIV5_SHIFT +: ACC_W];

	// Band tests against target * 1.04 and target * 0.82
	assign over_lhs  = CMP_W'(acc_avg) * OVER_ACC_MUL;
	assign over_rhs  = CMP_W'(cfg.target) * OVER_TGT_MUL;
	assign under_lhs = CMP_W'(acc_avg) * UNDER_ACC_MUL;
	assign under_rhs = CMP_W'(cfg.target) * UNDER_TGT_MUL;
	assign is_over   = over_lhs > over_rhs;
	assign is_under  = under_lhs < under_rhs;

	// Saturating counters and the stepped scale values
	assign over_inc  = (over_q == COUNT_MAX) ? COUNT_MAX : over_q + 4'd1;
	assign under_inc = (under_q == COUNT_MAX) ? COUNT_MAX : under_q + 4'd1;
	assign scale_dn  = (scale_q > SCALE_STEP) ? scale_q - SCALE_STEP : '0;
	assign scale_up  = {1'b0, scale_q} + {1'b0, SCALE_STEP};

	// Next state
	always_comb begin
		acc_d   = acc_q;
		scale_d = scale_q;
		over_d  = over_q;
		under_d = under_q;
		if (kind == KIND_RESTART) begin
			acc_d   = {cfg.target, 4'b0000};
			scale_d = cfg.scale_max;
			over_d  = '0;
			under_d = '0;
		end else if (sample_time != '0) begin
			acc_d = acc_avg;
			priority if (is_over) begin
				under_d = '0;
				if (over_inc >= cfg.over_need) begin
					scale_d = (scale_dn < cfg.scale_min) ? cfg.scale_min : scale_dn;
					over_d  = '0;
				end else begin
					over_d = over_inc;
				end
			end else if (is_under) begin
				over_d = '0;
				if (under_inc >= cfg.under_need) begin
					scale_d = (scale_up > {1'b0, cfg.scale_max}) ? cfg.scale_max
					                                             : scale_up[SCALE_W-1:0];
					under_d = '0;
				end else begin
					under_d = under_inc;
				end
			end else begin
				over_d  = '0;
				under_d = '0;
			end
		end
	end

	// State registers; reset holds the restart values of the reset registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= {TARGET_RESET, 4'b0000};
			scale_q <= MAX_SCALE_RESET;
			over_q  <= '0;
			under_q <= '0;
		end else if (upd_en) begin
			acc_q   <= acc_d;
			scale_q <= scale_d;
			over_q  <= over_d;
			under_q <= under_d;
		end
	end

	assign res.scale_level   = scale_d;
	assign res.scale_changed = (scale_d != scale_q);
	assign res.smoothed_time = acc_d[ACC_W-1:4];

endmodule

>>> rtl/dynamic_resolution_scale_controller_unit.sv
// ----------------------------------------------------------------------------
// Dynamic resolution scale controller
// Smooths frame times and steps the render scale up or down by 1/16.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the item channel (valid/ready): kind 0 restarts the
//   state from the registers, kind 1 carries a frame time in Q10.8 ms,
//   where zero marks an invalid sample that leaves the state alone.
//   Each item yields exactly one transaction on the result channel with
//   the render scale (Q1.8), a scale-changed flag and the smoothed time.
//   Registers are written through wr_en/wr_index/wr_data while the block
//   is idle; they take effect on the next item.
//   From acceptance, an item goes through the input register, then
//   the averaging, band test and scale step into the result register.
//   One item is accepted every cycle unless the receiver stalls; the
//   state loop closes through the divide-by-five multiply and compares.
//   Reset loads the register defaults and the matching restart state.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item before ready falls.
// ----------------------------------------------------------------------------
module dynamic_resolution_scale_controller_unit import drsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	drsc_in_if.sink           item,
	drsc_out_if.source        result,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data
);

	cfg_eff_t          cfg;
	result_t           res_d;
	result_t           res_q;
	logic              valid_s1;
	logic              kind_s1;
	logic [TIME_W-1:0] sample_time_s1;
	logic              out_valid_q;
	logic              advance;

	drsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	drsc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.upd_en      (advance),
		.kind        (kind_s1),
		.sample_time (sample_time_s1),
		.res         (res_d)
	);

	// The input stage moves on whenever the result register is free.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1        <= item.kind;
			sample_time_s1 <= item.sample_time;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.scale_level   = res_q.scale_level;
	assign result.scale_changed = res_q.scale_changed;
	assign result.smoothed_time = res_q.smoothed_time;

	// The delivered scale always lies within the legal range.
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.scale_level >= SCALE_LOW && result.scale_level <= SCALE_ONE))
		else $error("render scale out of range");

	// An invalid sample never moves the scale.
	a_zero_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind_s1 == KIND_SAMPLE && sample_time_s1 == '0) |=> !res_q.scale_changed)
		else $error("zero sample changed the scale");

	// Input back-pressure only when both stages are full and the output stalls.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without cause");

	// Every item leaving the input stage lands in the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost");

endmodule
